// ===== design/tplc_pkg.sv =====
// Package: widths, status codes and pipeline side payload for the triangle locator.
package tplc_pkg;
  localparam int CW  = 32;
  localparam int FB  = 16;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 1;
  localparam int AW  = NW + 1;
  localparam int SW  = AW + 1;
  localparam int RMW = SW + FB;
  localparam int QW  = FB + 1;
  localparam int GUW = DW + QW + 1;
  localparam int RW  = GUW + 2;
  localparam int HB  = RW / 2;
  localparam int EW  = 2 * RW + 1;
  localparam int TW  = 31;

  localparam logic [1:0] ST_INSIDE = 2'd0;
  localparam logic [1:0] ST_PROJ   = 2'd1;
  localparam logic [1:0] ST_FAR    = 2'd2;
  localparam logic [1:0] ST_DEGEN  = 2'd3;

  localparam logic REG_TOL = 1'b0;
  localparam logic REG_THR = 1'b1;

  typedef struct packed {
    logic signed [DW-1:0] g00;
    logic signed [DW-1:0] g10;
    logic signed [DW-1:0] g01;
    logic signed [DW-1:0] g11;
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic                 degen;
    logic                 in_tri;
  } side_t;
endpackage

// ===== design/tplc_div.sv =====
// Pipelined restoring divider: two quotients floor(num * 2^FB / den), one bit per stage.
module tplc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  logic [tplc_pkg::AW-1:0] num_a,
  input  logic [tplc_pkg::AW-1:0] num_b,
  input  logic [tplc_pkg::SW-1:0] den,
  input  tplc_pkg::side_t       side_in,
  output logic                  out_v,
  output logic [tplc_pkg::QW-1:0] q_a,
  output logic [tplc_pkg::QW-1:0] q_b,
  output tplc_pkg::side_t       side_out
);
  import tplc_pkg::*;

  logic [RMW-1:0] ra_r   [0:FB];
  logic [RMW-1:0] rb_r   [0:FB];
  logic [QW-1:0]  qa_r   [0:FB];
  logic [QW-1:0]  qb_r   [0:FB];
  logic [SW-1:0]  den_r  [0:FB];
  side_t          side_r [0:FB];
  logic [FB:0]    v_r;

  genvar k;
  generate
    for (k = 0; k <= FB; k++) begin : g_stage
      logic [RMW-1:0] ra_in, rb_in, dsh, ra_nxt, rb_nxt;
      logic [QW-1:0]  qa_in, qb_in, qa_nxt, qb_nxt;
      logic [SW-1:0]  den_in;
      side_t          side_in_k;
      logic           v_in, fa, fb;

      if (k == 0) begin : g_first
        assign ra_in     = RMW'(num_a) << FB;
        assign rb_in     = RMW'(num_b) << FB;
        assign qa_in     = '0;
        assign qb_in     = '0;
        assign den_in    = den;
        assign side_in_k = side_in;
        assign v_in      = in_v;
      end else begin : g_next
        assign ra_in     = ra_r[k-1];
        assign rb_in     = rb_r[k-1];
        assign qa_in     = qa_r[k-1];
        assign qb_in     = qb_r[k-1];
        assign den_in    = den_r[k-1];
        assign side_in_k = side_r[k-1];
        assign v_in      = v_r[k-1];
      end

      always_comb begin
        dsh    = RMW'(den_in) << (FB - k);
        fa     = (dsh <= ra_in);
        fb     = (dsh <= rb_in);
        ra_nxt = fa ? (ra_in - dsh) : ra_in;
        rb_nxt = fb ? (rb_in - dsh) : rb_in;
        qa_nxt = qa_in | (QW'(fa) << (FB - k));
        qb_nxt = qb_in | (QW'(fb) << (FB - k));
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_in;
        end
        if (en) begin
          ra_r[k]   <= ra_nxt;
          rb_r[k]   <= rb_nxt;
          qa_r[k]   <= qa_nxt;
          qb_r[k]   <= qb_nxt;
          den_r[k]  <= den_in;
          side_r[k] <= side_in_k;
        end
      end
    end
  endgenerate

  assign out_v    = v_r[FB];
  assign q_a      = qa_r[FB];
  assign q_b      = qb_r[FB];
  assign side_out = side_r[FB];
endmodule

// ===== design/triangle_point_to_local_coords_top.sv =====
// Top level: barycentric point location in a linear triangle, fully pipelined.
//
// Input channel in_*: vertices A, B, C and point P, signed Q16.16, valid/ready.
// Output channel out_*: local_first, local_second (Q1.16, 65536 is one), found,
// status (inside, projected within tolerance, too far, degenerate).
// Config port cfg_*: index 0 tolerance, index 1 det_threshold; write while idle.
// Throughput: one transfer per cycle while the receiver does not stall. The path has
// 26 register stages (5 setup stages, 17 divider stages, one per quotient bit,
// 3 residual stages, output register).
// Reset clears all stage valid bits and sets tolerance 0, det_threshold 1.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops; no item is lost or repeated. in_ready stays high whenever the
// output register is empty or is being drained in the same cycle.
module triangle_point_to_local_coords_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [30:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    in_vertex_a_x,
  input  logic signed [31:0]    in_vertex_a_y,
  input  logic signed [31:0]    in_vertex_b_x,
  input  logic signed [31:0]    in_vertex_b_y,
  input  logic signed [31:0]    in_vertex_c_x,
  input  logic signed [31:0]    in_vertex_c_y,
  input  logic signed [31:0]    in_point_x,
  input  logic signed [31:0]    in_point_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [16:0]           out_local_first,
  output logic [16:0]           out_local_second,
  output logic                  out_found,
  output logic [1:0]            out_status
);
  import tplc_pkg::*;

  logic          en;
  logic [TW-1:0] tol_r, thr_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
      thr_r <= TW'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TOL: tol_r <= cfg_wdata;
        REG_THR: thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: edge vectors
  logic v1_r;
  side_t s1_r;
  // stage 2: products
  logic v2_r;
  side_t s2_r;
  logic signed [PW-1:0] p_det1_r, p_det2_r, p_n01_r, p_n02_r, p_n11_r, p_n12_r;
  // stage 3: determinant and numerators
  logic v3_r;
  side_t s3_r;
  logic signed [NW-1:0] det_r, n0_r, n1_r;
  // stage 4: sign fix
  logic v4_r;
  side_t s4_r;
  logic signed [AW-1:0] deta_r, n0a_r, n1a_r;
  // stage 5: degeneracy, clamp and denominator
  logic v5_r;
  side_t s5_r;
  logic [AW-1:0] a_r, b_r;
  logic [SW-1:0] den_r;

  logic dv;
  logic [QW-1:0] dq_a, dq_b;
  side_t ds;

  logic v6_r, v7_r, v8_r;
  side_t s6_r, s7_r, s8_r;
  logic [QW-1:0] u6_r, w6_r, u7_r, w7_r, u8_r, w8_r;
  logic signed [GUW-1:0] gu00_r, gu01_r, gu10_r, gu11_r;
  logic [RW-1:0] m0_r, m1_r;
  logic [2*(RW-HB)-1:0] hh0_r, hh1_r;
  logic [RW-1:0] hl0_r, hl1_r;
  logic [2*HB-1:0] ll0_r, ll1_r;
  logic [2*TW-1:0] tsq_r;

  logic ov_r;

  assign en       = !ov_r || out_ready;
  assign in_ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= dv;       v7_r <= v6_r; v8_r <= v7_r; ov_r <= v8_r;
    end
  end

  // combinational logic for stage 5, the residual stages and the output status
  logic signed [RW-1:0] r0_nxt, r1_nxt;
  logic [EW-1:0] e_nxt, tq_nxt;
  logic [1:0] st_nxt;
  logic [SW-1:0] s_sum, d_abs;
  logic n0neg, n1neg;
  side_t s5_nxt;

  always_comb begin
    n0neg  = n0a_r[AW-1];
    n1neg  = n1a_r[AW-1];
    s_sum  = SW'(n0neg ? '0 : n0a_r) + SW'(n1neg ? '0 : n1a_r);
    d_abs  = SW'(deta_r);
    s5_nxt        = s4_r;
    s5_nxt.degen  = (deta_r < $signed(AW'({thr_r, {FB{1'b0}}}))) || (deta_r == '0);
    s5_nxt.in_tri = !n0neg && !n1neg && (s_sum <= d_abs);
    r0_nxt = (RW'(s6_r.d0) <<< FB) - RW'(gu00_r) - RW'(gu01_r);
    r1_nxt = (RW'(s6_r.d1) <<< FB) - RW'(gu10_r) - RW'(gu11_r);
    e_nxt  = (EW'(hh0_r) << (2*HB)) + (EW'(hl0_r) << (HB+1)) + EW'(ll0_r)
           + (EW'(hh1_r) << (2*HB)) + (EW'(hl1_r) << (HB+1)) + EW'(ll1_r);
    tq_nxt = EW'(tsq_r) << (2*FB);
    if (s8_r.degen) begin
      st_nxt = ST_DEGEN;
    end else if (s8_r.in_tri) begin
      st_nxt = ST_INSIDE;
    end else if (e_nxt < tq_nxt) begin
      st_nxt = ST_PROJ;
    end else begin
      st_nxt = ST_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.g00    <= DW'(in_vertex_b_x) - DW'(in_vertex_a_x);
      s1_r.g10    <= DW'(in_vertex_b_y) - DW'(in_vertex_a_y);
      s1_r.g01    <= DW'(in_vertex_c_x) - DW'(in_vertex_a_x);
      s1_r.g11    <= DW'(in_vertex_c_y) - DW'(in_vertex_a_y);
      s1_r.d0     <= DW'(in_point_x) - DW'(in_vertex_a_x);
      s1_r.d1     <= DW'(in_point_y) - DW'(in_vertex_a_y);
      s1_r.degen  <= 1'b0;
      s1_r.in_tri <= 1'b0;

      s2_r     <= s1_r;
      p_det1_r <= s1_r.g00 * s1_r.g11;
      p_det2_r <= s1_r.g01 * s1_r.g10;
      p_n01_r  <= s1_r.g11 * s1_r.d0;
      p_n02_r  <= s1_r.g01 * s1_r.d1;
      p_n11_r  <= s1_r.g00 * s1_r.d1;
      p_n12_r  <= s1_r.g10 * s1_r.d0;

      s3_r  <= s2_r;
      det_r <= NW'(p_det1_r) - NW'(p_det2_r);
      n0_r  <= NW'(p_n01_r) - NW'(p_n02_r);
      n1_r  <= NW'(p_n11_r) - NW'(p_n12_r);

      s4_r   <= s3_r;
      deta_r <= det_r[NW-1] ? -AW'(det_r) : AW'(det_r);
      n0a_r  <= det_r[NW-1] ? -AW'(n0_r)  : AW'(n0_r);
      n1a_r  <= det_r[NW-1] ? -AW'(n1_r)  : AW'(n1_r);

      s5_r        <= s5_nxt;
      a_r         <= n0neg ? '0 : AW'(n0a_r);
      b_r         <= n1neg ? '0 : AW'(n1a_r);
      den_r       <= (s_sum > d_abs) ? s_sum : d_abs;

      s6_r   <= ds;
      u6_r   <= dq_a;
      w6_r   <= dq_b;
      gu00_r <= ds.g00 * $signed({1'b0, dq_a});
      gu01_r <= ds.g01 * $signed({1'b0, dq_b});
      gu10_r <= ds.g10 * $signed({1'b0, dq_a});
      gu11_r <= ds.g11 * $signed({1'b0, dq_b});

      s7_r <= s6_r;
      u7_r <= u6_r;
      w7_r <= w6_r;
      m0_r <= r0_nxt[RW-1] ? RW'(-r0_nxt) : RW'(r0_nxt);
      m1_r <= r1_nxt[RW-1] ? RW'(-r1_nxt) : RW'(r1_nxt);

      s8_r  <= s7_r;
      u8_r  <= u7_r;
      w8_r  <= w7_r;
      hh0_r <= m0_r[RW-1:HB] * m0_r[RW-1:HB];
      hh1_r <= m1_r[RW-1:HB] * m1_r[RW-1:HB];
      hl0_r <= RW'(m0_r[RW-1:HB] * m0_r[HB-1:0]);
      hl1_r <= RW'(m1_r[RW-1:HB] * m1_r[HB-1:0]);
      ll0_r <= m0_r[HB-1:0] * m0_r[HB-1:0];
      ll1_r <= m1_r[HB-1:0] * m1_r[HB-1:0];
      tsq_r <= tol_r * tol_r;

      out_status       <= st_nxt;
      out_found        <= (st_nxt == ST_INSIDE) || (st_nxt == ST_PROJ);
      out_local_first  <= ((st_nxt == ST_INSIDE) || (st_nxt == ST_PROJ)) ? u8_r : '0;
      out_local_second <= ((st_nxt == ST_INSIDE) || (st_nxt == ST_PROJ)) ? w8_r : '0;
    end
  end

  tplc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v5_r),
    .num_a    (a_r),
    .num_b    (b_r),
    .den      (den_r),
    .side_in  (s5_r),
    .out_v    (dv),
    .q_a      (dq_a),
    .q_b      (dq_b),
    .side_out (ds)
  );

  assign out_valid = ov_r;
endmodule

// ===== design/tplc_checker.sv =====
// Checker: port-level properties of the triangle locator, bound to the top level.
module tplc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_local_first,
  input logic [16:0] out_local_second,
  input logic        out_found,
  input logic [1:0]  out_status
);
  import tplc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_found == ((out_status == ST_INSIDE) || (out_status == ST_PROJ)))
    else $error("found disagrees with status");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_local_first == '0) && (out_local_second == '0))
    else $error("rejected result carries coordinates");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_local_first <= 17'd65536) && (out_local_second <= 17'd65536))
    else $error("coordinate above one");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind triangle_point_to_local_coords_top tplc_checker u_tplc_checker (.*);
